// File: rtl/clcd_pkg.sv
`timescale 1ns / 1ps

package clcd_pkg;

	// Sequencer steps. The initialization commands occupy a contiguous range
	// so that the next command is found by stepping the state.
	typedef enum logic [4:0] {
		ST_IDLE      = 5'd0,
		ST_PWR_WAIT  = 5'd1,
		ST_INIT_N1   = 5'd2,
		ST_WAIT1     = 5'd3,
		ST_INIT_N2   = 5'd4,
		ST_WAIT2     = 5'd5,
		ST_INIT_N3   = 5'd6,
		ST_WAIT3     = 5'd7,
		ST_INIT_N4   = 5'd8,
		ST_CMD_0     = 5'd9,
		ST_CMD_1     = 5'd10,
		ST_CMD_2     = 5'd11,
		ST_CMD_3     = 5'd12,
		ST_CMD_4     = 5'd13,
		ST_CMD_5     = 5'd14,
		ST_CMD_6     = 5'd15,
		ST_USER      = 5'd16
	} seq_t;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_SEND  = 2'd1,
		REQ_INIT  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		REG_E_HIGH     = 2'd0,
		REG_POWER_UP   = 2'd1,
		REG_FIRST_WAIT = 2'd2,
		REG_SHORT_WAIT = 2'd3
	} reg_idx_t;

	localparam int unsigned TICK_W = 10;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	localparam logic [7:0]        E_HIGH_RST     = 8'd20;
	localparam logic [TICK_W-1:0] POWER_UP_RST   = 10'd150;
	localparam logic [7:0]        FIRST_WAIT_RST = 8'd50;
	localparam logic [7:0]        SHORT_WAIT_RST = 8'd2;

	localparam logic [3:0] NIB_INIT_3 = 4'h3;
	localparam logic [3:0] NIB_INIT_2 = 4'h2;

	// Command byte sent while the sequencer sits in the given command step.
	function automatic logic [7:0] init_cmd(input seq_t st);
		logic [7:0] cmd;
		unique case (st)
			ST_CMD_0: cmd = 8'h28;
			ST_CMD_1: cmd = 8'h08;
			ST_CMD_2: cmd = 8'h01;
			ST_CMD_3: cmd = 8'h06;
			ST_CMD_4: cmd = 8'h1C;
			ST_CMD_5: cmd = 8'h02;
			ST_CMD_6: cmd = 8'h0C;
			default:  cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

// File: rtl/char_lcd_nibble_interface.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: byte_value; s_tuser: req_type, is_char
// m_        out  m_tvalid/m_tready    m_tdata: lcd_data, lcd_rs, lcd_e, busy_res, rejected
// APB       in   psel/penable/pready  four timing registers at 0x0, 0x4, 0x8, 0xC
//
// Every input beat is handled in the cycle it is accepted: the sequencer state
// and the result beat are both computed by one level of next-state logic and
// registered at the accepting edge, so one beat per clock is sustained
// while s_tready is high. Results go into a two-entry output buffer;
// s_tready only drops when both entries hold beats that the sink has not yet taken.
// arst_n clears the sequencer to idle, empties the buffer and loads the
// register defaults (enable 20, power-up 150, first wait 50, short wait 2).

module char_lcd_nibble_interface (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic [2:0]  s_tuser,   // [1:0] req_type, [2] is_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] lcd_data, [4] lcd_rs, [5] lcd_e,
	                               // [6] busy_res, [7] rejected
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import clcd_pkg::*;

	// Configuration registers.
	logic [7:0]        e_high_q;
	logic [TICK_W-1:0] power_up_q;
	logic [7:0]        first_wait_q;
	logic [7:0]        short_wait_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_high_q     <= E_HIGH_RST;
			power_up_q   <= POWER_UP_RST;
			first_wait_q <= FIRST_WAIT_RST;
			short_wait_q <= SHORT_WAIT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_E_HIGH:     e_high_q     <= pwdata[7:0];
				REG_POWER_UP:   power_up_q   <= pwdata[TICK_W-1:0];
				REG_FIRST_WAIT: first_wait_q <= pwdata[7:0];
				REG_SHORT_WAIT: short_wait_q <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_E_HIGH:     prdata = {24'd0, e_high_q};
			REG_POWER_UP:   prdata = {{(32-TICK_W){1'b0}}, power_up_q};
			REG_FIRST_WAIT: prdata = {24'd0, first_wait_q};
			REG_SHORT_WAIT: prdata = {24'd0, short_wait_q};
		endcase
	end

	// Sequencer state.
	seq_t              seq_q;
	logic [TICK_W-1:0] cnt_q;
	logic [7:0]        pend_q;
	logic              low_q;
	logic              rs_q;
	logic [3:0]        data_q;
	logic              en_q;

	seq_t              seq_n;
	logic [TICK_W-1:0] cnt_n;
	logic [7:0]        pend_n;
	logic              low_n;
	logic              rs_n;
	logic [3:0]        data_n;
	logic              en_n;
	logic              rej_n;

	logic              in_acc;
	req_t              req;
	logic [TICK_W-1:0] cnt_inc;
	logic [TICK_W-1:0] wait_len;
	logic [TICK_W-1:0] e_len;
	logic [7:0]        cmd_next;
	logic              in_wait;

	assign in_acc   = s_tvalid & s_tready;
	assign req      = req_t'(s_tuser[1:0]);
	assign cnt_inc  = (cnt_q == TICK_MAX) ? cnt_q : cnt_q + 1'b1;
	// An enable time of zero behaves as one tick.
	assign e_len    = (e_high_q == 8'd0) ? TICK_W'(1) : TICK_W'(e_high_q);
	assign cmd_next = init_cmd(seq_t'(seq_q + 5'd1));
	assign in_wait  = (seq_q == ST_PWR_WAIT) || (seq_q == ST_WAIT1) ||
	                  (seq_q == ST_WAIT2) || (seq_q == ST_WAIT3);

	always_comb begin
		unique case (seq_q)
			ST_PWR_WAIT: wait_len = power_up_q;
			ST_WAIT1:    wait_len = TICK_W'(first_wait_q);
			default:     wait_len = TICK_W'(short_wait_q);
		endcase
	end

	always_comb begin
		seq_n  = seq_q;
		cnt_n  = cnt_q;
		pend_n = pend_q;
		low_n  = low_q;
		rs_n   = rs_q;
		data_n = data_q;
		en_n   = en_q;
		rej_n  = 1'b0;

		unique case (req)
			REQ_TICK: begin
				if (seq_q == ST_IDLE) begin
					// Ticks while idle leave everything as it is.
				end else if (in_wait) begin
					cnt_n = cnt_inc;
					if (cnt_inc >= wait_len) begin
						seq_n  = (seq_q == ST_WAIT3) ? ST_INIT_N4 : seq_t'(seq_q + 5'd1);
						data_n = (seq_q == ST_WAIT3) ? NIB_INIT_2 : NIB_INIT_3;
						en_n   = 1'b0;
						cnt_n  = '0;
					end
				end else if (!en_q) begin
					// Setup tick done: raise the strobe.
					en_n  = 1'b1;
					cnt_n = '0;
				end else begin
					cnt_n = cnt_inc;
					if (cnt_inc >= e_len) begin
						en_n  = 1'b0;
						cnt_n = '0;
						priority if (seq_q == ST_INIT_N1) begin
							seq_n = ST_WAIT1;
							if (first_wait_q == 8'd0) begin
								seq_n  = ST_INIT_N2;
								data_n = NIB_INIT_3;
							end
						end else if (seq_q == ST_INIT_N2 || seq_q == ST_INIT_N3) begin
							seq_n = seq_t'(seq_q + 5'd1);
							// A zero short wait skips straight to the next nibble.
							if (short_wait_q == 8'd0) begin
								seq_n  = seq_t'(seq_q + 5'd2);
								data_n = (seq_q == ST_INIT_N3) ? NIB_INIT_2 : NIB_INIT_3;
							end
						end else if (seq_q == ST_INIT_N4) begin
							seq_n  = ST_CMD_0;
							pend_n = init_cmd(ST_CMD_0);
							low_n  = 1'b0;
							data_n = 4'(init_cmd(ST_CMD_0) >> 4);
						end else if (!low_q) begin
							low_n  = 1'b1;
							data_n = pend_q[3:0];
						end else if (seq_q >= ST_CMD_0 && seq_q < ST_CMD_6) begin
							seq_n  = seq_t'(seq_q + 5'd1);
							pend_n = cmd_next;
							low_n  = 1'b0;
							data_n = cmd_next[7:4];
						end else begin
							seq_n = ST_IDLE;
							low_n = 1'b0;
						end
					end
				end
			end
			REQ_SEND: begin
				if (seq_q != ST_IDLE) begin
					rej_n = 1'b1;
				end else begin
					rs_n   = s_tuser[2];
					seq_n  = ST_USER;
					pend_n = s_tdata;
					low_n  = 1'b0;
					data_n = s_tdata[7:4];
					en_n   = 1'b0;
					cnt_n  = '0;
				end
			end
			REQ_INIT: begin
				if (seq_q != ST_IDLE) begin
					rej_n = 1'b1;
				end else begin
					rs_n  = 1'b0;
					en_n  = 1'b0;
					low_n = 1'b0;
					cnt_n = '0;
					seq_n = ST_PWR_WAIT;
					// Data pins keep their level until the first nibble.
					if (power_up_q == '0) begin
						seq_n  = ST_INIT_N1;
						data_n = NIB_INIT_3;
					end
				end
			end
			REQ_NONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= ST_IDLE;
			cnt_q  <= '0;
			pend_q <= '0;
			low_q  <= 1'b0;
			rs_q   <= 1'b0;
			data_q <= '0;
			en_q   <= 1'b0;
		end else if (in_acc) begin
			seq_q  <= seq_n;
			cnt_q  <= cnt_n;
			pend_q <= pend_n;
			low_q  <= low_n;
			rs_q   <= rs_n;
			data_q <= data_n;
			en_q   <= en_n;
		end
	end

	// Two-entry result buffer.
	logic [7:0] res_n;
	logic [7:0] buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       out_acc;

	assign res_n    = {rej_n, (seq_n != ST_IDLE), en_n, rs_n, data_n};
	assign s_tready = (fill_q != 2'd2);
	assign m_tvalid = (fill_q != 2'd0);
	assign m_tdata  = buf_q[rd_ptr_q];
	assign out_acc  = m_tvalid & m_tready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			buf_q[wr_ptr_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (out_acc) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (in_acc && !out_acc) begin
				fill_q <= fill_q + 2'd1;
			end else if (!in_acc && out_acc) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// The buffer never holds more than two beats.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("result buffer overfilled");

	// A push without a pop grows the buffer by exactly one beat.
	a_fill_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !out_acc) |=> (fill_q == $past(fill_q) + 2'd1))
		else $error("result buffer count lost a beat");

	// The strobe is always low once the sequencer has gone idle.
	a_idle_e_low: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == ST_IDLE) |-> !en_q)
		else $error("enable high while idle");

	// A tick while idle leaves the sequencer idle.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req == REQ_TICK && seq_q == ST_IDLE) |=> (seq_q == ST_IDLE))
		else $error("tick woke an idle sequencer");

endmodule
